### hdl/utu_pkg.sv
`timescale 1ns / 1ps

package utu_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // one or two utf-16 units waiting to be sent as bytes
    typedef struct packed {
        logic        two_units;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } t_unit_req;

endpackage

### hdl/utu_front.sv
`timescale 1ns / 1ps

module utu_front
    import utu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_cmd,
    input  logic [7:0] i_byte,
    output logic      o_ready,
    input  logic      i_q_full,
    output logic      o_push,
    output t_unit_req o_req
);

    logic [20:0] r_partial;
    logic [1:0]  r_pending;
    logic [20:0] n_partial;
    logic [1:0]  n_pending;
    logic        accept;
    logic        emit;
    logic [20:0] code;
    logic [20:0] v;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign code    = {r_partial[14:0], i_byte[5:0]};
    assign v       = code - 21'h10000;

    always_comb begin
        n_partial = r_partial;
        n_pending = r_pending;
        emit      = 1'b0;
        o_req     = '0;
        if (i_cmd == CMD_FINISH) begin
            n_partial = '0;
            n_pending = '0;
            emit      = 1'b1;
        end else if (r_pending == 2'd0) begin
            if (i_byte[7] == 1'b0) begin
                emit        = 1'b1;
                o_req.unit0 = {8'h00, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_partial = {16'd0, i_byte[4:0]};
                n_pending = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_partial = {17'd0, i_byte[3:0]};
                n_pending = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_partial = {18'd0, i_byte[2:0]};
                n_pending = 2'd3;
            end
        end else if (i_byte[7:6] != 2'b10) begin
            n_partial = '0;
            n_pending = '0;
        end else begin
            n_partial = code;
            n_pending = r_pending - 2'd1;
            if (r_pending == 2'd1) begin
                emit      = 1'b1;
                n_partial = '0;
                if (code[20:16] == 5'd0) begin
                    o_req.unit0 = code[15:0];
                end else begin
                    // surrogate pair, with no range check on the code point
                    o_req.two_units = 1'b1;
                    o_req.unit0     = 16'hD800 + {5'd0, v[20:10]};
                    o_req.unit1     = 16'hDC00 + {6'd0, v[9:0]};
                end
            end
        end
    end

    assign o_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pending <= '0;
        end else if (accept) begin
            r_partial <= n_partial;
            r_pending <= n_pending;
        end
    end

endmodule

### hdl/utu_queue.sv
`timescale 1ns / 1ps

module utu_queue
    import utu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_unit_req i_req,
    input  logic      i_pop,
    output t_unit_req o_req,
    output logic      o_full,
    output logic      o_empty
);

    t_unit_req r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_req   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/utu_back.sv
`timescale 1ns / 1ps

module utu_back
    import utu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_unit_req  i_req,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_data,
    output logic       o_last,
    input  logic       i_ready
);

    logic      r_busy;
    logic [1:0] r_idx;
    t_unit_req r_cur;
    logic      done;

    always_comb begin
        case (r_idx)
            2'd0:    o_data = r_cur.unit0[7:0];
            2'd1:    o_data = r_cur.unit0[15:8];
            2'd2:    o_data = r_cur.unit1[7:0];
            default: o_data = r_cur.unit1[15:8];
        endcase
    end

    assign o_valid = r_busy;
    assign o_last  = (r_idx == 2'd3) || (r_idx == 2'd1 && !r_cur.two_units);
    assign done    = r_busy && i_ready && o_last;
    assign o_pop   = !i_q_empty && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

### hdl/utf8_to_utf16le_stream_top.sv
`timescale 1ns / 1ps
// channel   dir  tdata              tuser        tlast
// s_axis    in   [7:0] in_byte      [0] cmd      -
// m_axis    out  [7:0] out_byte     -            last
//
// an input request is decoded in the cycle it is accepted; a request that
// produces output yields 2 output bytes (4 for a surrogate pair), sent by the
// serializer at one byte per cycle while the sink is ready. a 2-entry queue lets
// input continue while output stalls. reset is synchronous, active low, and
// clears decode state, the queue and the serializer.

module utf8_to_utf16le_stream_top
    import utu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tuser,   // [0] cmd
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);

    t_unit_req push_req;
    t_unit_req head_req;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;

    utu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_cmd    (i_s_axis_tuser),
        .i_byte   (i_s_axis_tdata),
        .o_ready  (o_s_axis_tready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_req    (push_req)
    );

    utu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .i_pop   (pop),
        .o_req   (head_req),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    utu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_req     (head_req),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .o_data    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast),
        .i_ready   (i_m_axis_tready)
    );

endmodule

### tb/utf8_to_utf16le_stream_top_tb.sv
`timescale 1ns / 1ps

module utf8_to_utf16le_stream_top_tb;
    import utu_pkg::*;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_utf16_byte;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] in_byte
    logic       i_s_axis_tuser;   // [0] cmd
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;   // [7:0] out_byte
    logic       o_m_axis_tlast;

    t_utf16_byte utf16_q[$];
    logic [20:0] code_acc;
    logic [1:0]  cont_left;

    int src_idle_pct;
    int snk_stall_pct;
    int snk_hold_cycles;
    int requests_sent;
    int bytes_checked;
    int finish_cnt;
    int pair_cnt;
    int mismatch_cnt;
    int err_cnt;

    utf8_to_utf16le_stream_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void add_exp_byte(input t_utf16_byte b);
        utf16_q.insert(utf16_q.size(), b);
    endfunction

    function automatic void push_unit(input logic [15:0] unit);
        t_utf16_byte b;
        b.last = 1'b0;
        b.data = unit[7:0];
        add_exp_byte(b);
        b.data = unit[15:8];
        add_exp_byte(b);
    endfunction

    function automatic void predict_utf16(input logic cmd, input logic [7:0] in_b);
        int          base;
        logic [20:0] v;
        t_utf16_byte tail;
        base = utf16_q.size();
        if (cmd == CMD_FINISH) begin
            push_unit(16'h0000);
            code_acc = '0;
            cont_left = '0;
            finish_cnt++;
        end else if (cont_left == 2'd0) begin
            if (in_b <= 8'h7F) begin
                push_unit({8'h00, in_b});
            end else if ((in_b & 8'hE0) == 8'hC0) begin
                code_acc = {16'd0, in_b[4:0]};
                cont_left = 2'd1;
            end else if ((in_b & 8'hF0) == 8'hE0) begin
                code_acc = {17'd0, in_b[3:0]};
                cont_left = 2'd2;
            end else if ((in_b & 8'hF8) == 8'hF0) begin
                code_acc = {18'd0, in_b[2:0]};
                cont_left = 2'd3;
            end
        end else if (in_b[7:6] != 2'b10) begin
            code_acc = '0;
            cont_left = '0;
        end else begin
            code_acc = {code_acc[14:0], in_b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                if (code_acc <= 21'h00FFFF) begin
                    push_unit(code_acc[15:0]);
                end else begin
                    v = code_acc - 21'h010000;
                    push_unit(16'hD800 + {5'd0, v[20:10]});
                    push_unit(16'hDC00 + {6'd0, v[9:0]});
                    pair_cnt++;
                end
                code_acc = '0;
            end
        end
        if (utf16_q.size() > base) begin
            tail = utf16_q.pop_back();
            tail.last = 1'b1;
            add_exp_byte(tail);
        end
    endfunction

    // prediction before check so a same-edge result cannot race its request
    always @(posedge i_clk) begin
        t_utf16_byte exp_b;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_utf16(i_s_axis_tuser, i_s_axis_tdata);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                bytes_checked++;
                if (utf16_q.size() == 0) begin
                    err_cnt++;
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected output byte %02h last %0b",
                                 o_m_axis_tdata, o_m_axis_tlast);
                    end
                end else begin
                    exp_b = utf16_q.pop_front();
                    if (exp_b.data !== o_m_axis_tdata || exp_b.last !== o_m_axis_tlast) begin
                        err_cnt++;
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch: expected byte %02h last %0b, got %02h last %0b",
                                     exp_b.data, exp_b.last, o_m_axis_tdata, o_m_axis_tlast);
                        end
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (snk_hold_cycles > 0) begin
            i_m_axis_tready = 1'b0;
            snk_hold_cycles = snk_hold_cycles - 1;
        end else begin
            i_m_axis_tready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] in_b);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser = cmd;
        i_s_axis_tdata = in_b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        requests_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (utf16_q.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        if (utf16_q.size() != 0) begin
            err_cnt++;
            $display("%0d expected output bytes never arrived", utf16_q.size());
            utf16_q.delete();
        end
    endtask

    task automatic send_utf8_char(input int len, input bit broken);
        logic [7:0] lead;
        logic [1:0] top;
        int         bad_pos;
        case (len)
            1: lead = 8'($urandom_range(127));
            2: lead = 8'hC0 | 8'($urandom_range(31));
            3: lead = 8'hE0 | 8'($urandom_range(15));
            default: lead = 8'hF0 | 8'($urandom_range(7));
        endcase
        send_item(CMD_DATA, lead);
        bad_pos = broken ? $urandom_range(1, len - 1) : len;
        for (int i = 1; i < len; i++) begin
            if (i == bad_pos) begin
                top = 2'($urandom_range(2));
                if (top == 2'd2) begin
                    top = 2'd3;
                end
                send_item(CMD_DATA, {top, 6'($urandom_range(63))});
                break;
            end
            send_item(CMD_DATA, 8'h80 | 8'($urandom_range(63)));
        end
    endtask

    task automatic test_directed();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'h41);
        send_item(CMD_DATA, 8'h7F);
        send_item(CMD_FINISH, 8'hFF);
        send_item(CMD_DATA, 8'hC2);
        send_item(CMD_DATA, 8'hA9);
        send_item(CMD_DATA, 8'hE2);
        send_item(CMD_DATA, 8'h82);
        send_item(CMD_DATA, 8'hAC);
        send_item(CMD_DATA, 8'hF0);
        send_item(CMD_DATA, 8'h9F);
        send_item(CMD_DATA, 8'h98);
        send_item(CMD_DATA, 8'h80);
        // beyond the unicode range, passed through the surrogate math unchecked
        send_item(CMD_DATA, 8'hF7);
        send_item(CMD_DATA, 8'hBF);
        send_item(CMD_DATA, 8'hBF);
        send_item(CMD_DATA, 8'hBF);
        send_item(CMD_DATA, 8'h80);
        send_item(CMD_DATA, 8'hF8);
        send_item(CMD_DATA, 8'hFF);
        // bad continuation, not taken as ascii
        send_item(CMD_DATA, 8'hE2);
        send_item(CMD_DATA, 8'h41);
        // finish drops the pending sequence
        send_item(CMD_DATA, 8'hF0);
        send_item(CMD_DATA, 8'h90);
        send_item(CMD_FINISH, 8'h00);
        // overlong form passes unchecked
        send_item(CMD_DATA, 8'hC0);
        send_item(CMD_DATA, 8'h80);
        wait_drained();
    endtask

    task automatic test_random_text(input int n_items, input int src_pct, input int snk_pct);
        int start;
        int kind;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        start = requests_sent;
        while (requests_sent - start < n_items) begin
            kind = $urandom_range(99);
            if (kind < 6) begin
                send_item(CMD_FINISH, 8'($urandom_range(255)));
            end else if (kind < 16) begin
                send_item(CMD_DATA, 8'($urandom_range(255)));
            end else if (kind < 24) begin
                send_utf8_char($urandom_range(2, 4), 1'b1);
            end else begin
                send_utf8_char($urandom_range(1, 4), 1'b0);
            end
        end
    endtask

    task automatic test_output_backpressure();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        snk_hold_cycles = 300;
        for (int i = 0; i < 12; i++) begin
            send_utf8_char($urandom_range(1, 4), 1'b0);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = 8'h00;
        i_s_axis_tuser = CMD_DATA;
        i_m_axis_tready = 1'b0;
        code_acc = '0;
        cont_left = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        snk_hold_cycles = 0;
        requests_sent = 0;
        bytes_checked = 0;
        finish_cnt = 0;
        pair_cnt = 0;
        mismatch_cnt = 0;
        err_cnt = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_text(28, 0, 0);
        test_random_text(28, 50, 0);
        wait_drained();
        test_random_text(28, 0, 50);
        test_random_text(28, 8, 8);
        test_output_backpressure();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (utf16_q.size() != 0) begin
            err_cnt++;
        end
        $display("covered %0d input requests, %0d output bytes checked", requests_sent,
                 bytes_checked);
        $display("including %0d finish commands and %0d surrogate pairs, %0d mismatches",
                 finish_cnt, pair_cnt, mismatch_cnt);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
